// File: rtl/smop_pkg.sv
// ----------------------------------------------------------------------------
// smop_pkg: shared types and constants of the message-out parser
// Byte codes, scan modes, outcome codes and the run record passed from the
// front scanner to the reply sequencer.
// ----------------------------------------------------------------------------
package smop_pkg;

  // Message codes
  localparam logic [7:0] MSG_EXTENDED  = 8'h01;
  localparam logic [7:0] MSG_ABORT     = 8'h06;
  localparam logic [7:0] MSG_REJECT    = 8'h07;
  localparam logic [7:0] MSG_BDR       = 8'h0C;
  localparam logic [7:0] EXT_CODE_SDTR = 8'h01;
  localparam logic [7:0] EXT_LEN_SDTR  = 8'h03;

  localparam logic [7:0] RUN_LEN_MAX   = 8'hFF;

  // Extended capture positions: length, code, period, offset
  localparam logic [2:0] CAP_CODE      = 3'd1;
  localparam logic [2:0] CAP_PERIOD    = 3'd2;
  localparam logic [2:0] CAP_OFFSET    = 3'd3;
  localparam logic [2:0] CAP_DONE      = 3'd4;

  // SDTR reply beats
  localparam logic [2:0] BEAT_EXT      = 3'd0;
  localparam logic [2:0] BEAT_LEN      = 3'd1;
  localparam logic [2:0] BEAT_CODE     = 3'd2;
  localparam logic [2:0] BEAT_PERIOD   = 3'd3;
  localparam logic [2:0] BEAT_OFFSET   = 3'd4;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_SYNC_EN   = 2'd0;
  localparam logic [1:0] CFG_MAX_PER   = 2'd1;
  localparam logic [1:0] CFG_MAX_OFF   = 2'd2;

  localparam logic [7:0] MAX_PER_RST   = 8'd50;
  localparam logic [7:0] MAX_OFF_RST   = 8'd16;

  typedef enum logic [1:0] {
    MODE_SCAN     = 2'd0,
    MODE_CAPTURE  = 2'd1,
    MODE_STOPPED  = 2'd2,
    MODE_OVERLONG = 2'd3
  } scan_mode_e;

  typedef enum logic [1:0] {
    PEND_GO    = 2'd0,
    PEND_ABORT = 2'd1,
    PEND_RESET = 2'd2,
    PEND_EXT   = 2'd3
  } pend_e;

  typedef enum logic [2:0] {
    OUT_GO       = 3'd0,
    OUT_ABORT    = 3'd1,
    OUT_RESET    = 3'd2,
    OUT_REJECT   = 3'd3,
    OUT_SDTR     = 3'd4,
    OUT_OVERLONG = 3'd5
  } outcome_e;

  // One finished run, as resolved by the front scanner
  typedef struct packed {
    outcome_e   outcome;
    logic       lun_valid;
    logic [4:0] lun;
    logic [7:0] period;
    logic [7:0] offset;
  } run_rec_t;

  // One result word
  typedef struct packed {
    outcome_e   outcome;
    logic       lun_valid;
    logic [4:0] lun;
    logic [7:0] sync_period;
    logic [7:0] sync_offset;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       run_last;
  } result_t;

endpackage

// File: rtl/smop_front.sv
// ----------------------------------------------------------------------------
// smop_front: message-out byte scanner
// Classifies each accepted byte, tracks the run state and resolves the run
// into one record on its last byte.
// ----------------------------------------------------------------------------
module smop_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          msg_byte_i,
  input  logic                last_byte_i,
  input  logic                sync_enable_i,
  output logic                rec_push_o,
  output smop_pkg::run_rec_t  rec_o
);

  smop_pkg::scan_mode_e mode_q, mode_d;
  smop_pkg::pend_e      pend_q, pend_d;
  logic [2:0]           cap_idx_q, cap_idx_d;
  logic [7:0]           ext_code_q, ext_code_d;
  logic [7:0]           ext_per_q, ext_per_d;
  logic [7:0]           ext_off_q, ext_off_d;
  logic                 lun_vld_q, lun_vld_d;
  logic [4:0]           lun_q, lun_d;
  logic [7:0]           cnt_q, cnt_d;

  // Next run state after scanning the byte
  always_comb begin
    mode_d     = mode_q;
    pend_d     = pend_q;
    cap_idx_d  = cap_idx_q;
    ext_code_d = ext_code_q;
    ext_per_d  = ext_per_q;
    ext_off_d  = ext_off_q;
    lun_vld_d  = lun_vld_q;
    lun_d      = lun_q;
    cnt_d      = cnt_q;
    if (mode_q != smop_pkg::MODE_OVERLONG) begin
      if (cnt_q == smop_pkg::RUN_LEN_MAX) begin
        mode_d = smop_pkg::MODE_OVERLONG;
      end else begin
        cnt_d = cnt_q + 8'd1;
        case (mode_q)
          smop_pkg::MODE_CAPTURE: begin
            if (cap_idx_q == smop_pkg::CAP_CODE) ext_code_d = msg_byte_i;
            if (cap_idx_q == smop_pkg::CAP_PERIOD) ext_per_d = msg_byte_i;
            if (cap_idx_q == smop_pkg::CAP_OFFSET) ext_off_d = msg_byte_i;
            cap_idx_d = cap_idx_q + 3'd1;
            if (cap_idx_d == smop_pkg::CAP_DONE) mode_d = smop_pkg::MODE_STOPPED;
          end
          smop_pkg::MODE_SCAN: begin
            if (msg_byte_i == smop_pkg::MSG_ABORT) begin
              pend_d = smop_pkg::PEND_ABORT;
              mode_d = smop_pkg::MODE_STOPPED;
            end else if (msg_byte_i == smop_pkg::MSG_BDR) begin
              pend_d = smop_pkg::PEND_RESET;
              mode_d = smop_pkg::MODE_STOPPED;
            end else if (msg_byte_i[7]) begin
              lun_vld_d = 1'b1;
              lun_d     = msg_byte_i[4:0];
            end else if (msg_byte_i == smop_pkg::MSG_EXTENDED) begin
              pend_d    = smop_pkg::PEND_EXT;
              mode_d    = smop_pkg::MODE_CAPTURE;
              cap_idx_d = 3'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Resolve the run from the post-scan state
  always_comb begin
    rec_push_o    = accept_i && last_byte_i;
    rec_o.lun_valid = lun_vld_d;
    rec_o.lun       = lun_d;
    rec_o.period    = ext_per_d;
    rec_o.offset    = ext_off_d;
    if (mode_d == smop_pkg::MODE_OVERLONG) begin
      rec_o.outcome = smop_pkg::OUT_OVERLONG;
    end else begin
      case (pend_d)
        smop_pkg::PEND_ABORT: rec_o.outcome = smop_pkg::OUT_ABORT;
        smop_pkg::PEND_RESET: rec_o.outcome = smop_pkg::OUT_RESET;
        smop_pkg::PEND_EXT: begin
          if (sync_enable_i && ext_code_d == smop_pkg::EXT_CODE_SDTR) begin
            rec_o.outcome = smop_pkg::OUT_SDTR;
          end else begin
            rec_o.outcome = smop_pkg::OUT_REJECT;
          end
        end
        default: rec_o.outcome = smop_pkg::OUT_GO;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= smop_pkg::MODE_SCAN;
      pend_q     <= smop_pkg::PEND_GO;
      cap_idx_q  <= 3'd0;
      ext_code_q <= 8'd0;
      ext_per_q  <= 8'd0;
      ext_off_q  <= 8'd0;
      lun_vld_q  <= 1'b0;
      lun_q      <= 5'd0;
      cnt_q      <= 8'd0;
    end else if (accept_i) begin
      if (last_byte_i) begin
        // clear the run state for the next run
        mode_q     <= smop_pkg::MODE_SCAN;
        pend_q     <= smop_pkg::PEND_GO;
        cap_idx_q  <= 3'd0;
        ext_code_q <= 8'd0;
        ext_per_q  <= 8'd0;
        ext_off_q  <= 8'd0;
        lun_vld_q  <= 1'b0;
        lun_q      <= 5'd0;
        cnt_q      <= 8'd0;
      end else begin
        mode_q     <= mode_d;
        pend_q     <= pend_d;
        cap_idx_q  <= cap_idx_d;
        ext_code_q <= ext_code_d;
        ext_per_q  <= ext_per_d;
        ext_off_q  <= ext_off_d;
        lun_vld_q  <= lun_vld_d;
        lun_q      <= lun_d;
        cnt_q      <= cnt_d;
      end
    end
  end

endmodule

// File: rtl/smop_fifo.sv
// ----------------------------------------------------------------------------
// smop_fifo: run record queue
// Small first-word-fall-through queue between the scanner and the sequencer.
// ----------------------------------------------------------------------------
module smop_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  smop_pkg::run_rec_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output smop_pkg::run_rec_t rdata_o,
  output logic               empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  smop_pkg::run_rec_t mem_q [DEPTH];
  logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]      cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + AW'(1);
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + AW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

// File: rtl/smop_back.sv
// ----------------------------------------------------------------------------
// smop_back: reply sequencer
// Takes run records, updates the stored sync values and emits the result
// words of each run through an output register.
// ----------------------------------------------------------------------------
module smop_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_empty_i,
  input  smop_pkg::run_rec_t rec_i,
  output logic               rec_pop_o,
  input  logic [7:0]         max_period_i,
  input  logic [7:0]         max_offset_i,
  output logic               res_valid_o,
  output smop_pkg::result_t  res_o,
  input  logic               res_pop_i
);

  smop_pkg::run_rec_t cur_q;
  logic               cur_vld_q;
  logic [2:0]         beat_q;
  logic [7:0]         per_q, off_q;
  smop_pkg::result_t  out_q, out_d;
  logic               out_vld_q;
  logic               load_out, last_beat, cur_done, fetch;
  logic [7:0]         per_clamp, off_clamp;

  assign load_out  = !out_vld_q || res_pop_i;
  assign last_beat = (cur_q.outcome != smop_pkg::OUT_SDTR) ||
                     (beat_q == smop_pkg::BEAT_OFFSET);
  assign cur_done  = cur_vld_q && load_out && last_beat;
  assign fetch     = !rec_empty_i && (!cur_vld_q || cur_done);
  assign rec_pop_o = fetch;

  assign per_clamp = (rec_i.period > max_period_i) ? max_period_i : rec_i.period;
  assign off_clamp = (rec_i.offset > max_offset_i) ? max_offset_i : rec_i.offset;

  // Build the word for the current beat
  always_comb begin
    out_d.outcome     = cur_q.outcome;
    out_d.lun_valid   = cur_q.lun_valid;
    out_d.lun         = cur_q.lun;
    out_d.sync_period = per_q;
    out_d.sync_offset = off_q;
    out_d.run_last    = last_beat;
    out_d.reply_valid = 1'b0;
    out_d.reply_byte  = 8'd0;
    case (cur_q.outcome)
      smop_pkg::OUT_REJECT: begin
        out_d.reply_valid = 1'b1;
        out_d.reply_byte  = smop_pkg::MSG_REJECT;
      end
      smop_pkg::OUT_SDTR: begin
        out_d.reply_valid = 1'b1;
        case (beat_q)
          smop_pkg::BEAT_EXT:    out_d.reply_byte = smop_pkg::MSG_EXTENDED;
          smop_pkg::BEAT_LEN:    out_d.reply_byte = smop_pkg::EXT_LEN_SDTR;
          smop_pkg::BEAT_CODE:   out_d.reply_byte = smop_pkg::EXT_CODE_SDTR;
          smop_pkg::BEAT_PERIOD: out_d.reply_byte = per_q;
          default:               out_d.reply_byte = off_q;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      beat_q    <= 3'd0;
      per_q     <= 8'd0;
      off_q     <= 8'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (fetch) begin
        cur_vld_q <= 1'b1;
        beat_q    <= 3'd0;
        // stored values change as the run is taken up
        case (rec_i.outcome)
          smop_pkg::OUT_RESET: off_q <= 8'd0;
          smop_pkg::OUT_SDTR: begin
            per_q <= per_clamp;
            off_q <= off_clamp;
          end
          default: ;
        endcase
      end else if (cur_done) begin
        cur_vld_q <= 1'b0;
      end else if (cur_vld_q && load_out) begin
        beat_q <= beat_q + 3'd1;
      end
      if (load_out) out_vld_q <= cur_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) cur_q <= rec_i;
    if (load_out && cur_vld_q) out_q <= out_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: rtl/scsi_message_out_parser.sv
// ----------------------------------------------------------------------------
// scsi_message_out_parser: target-side message-out parser with SDTR replies
// Scans message-out bytes, resolves each run and emits result words that
// carry the outcome, the LUN, the stored sync values and the reply bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------------
//   bytes in  push_i / full_o        msg_byte_i, last_byte_i
//   results   empty_o / pop_i        outcome_o, lun_valid_o, lun_o,
//                                    sync_period_o, sync_offset_o,
//                                    reply_valid_o, reply_byte_o, run_last_o
//   config    cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// One byte is taken every cycle while full_o is low; a run resolves on its last
// byte in the same cycle and its record joins the run queue.
// While pop_i takes every word, the sequencer sends one result word a cycle:
// one per run, five for an SDTR reply, so SDTR runs are bounded by that burst.
// Reset leaves the registers at sync off, period clamp 50, offset clamp 16,
// stored period and offset zero, and both queues empty.
// full_o rises only while the run queue (FIFO_DEPTH records) is full; a
// stalled pop_i holds the result word and backs up into that queue.
//
module scsi_message_out_parser #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte channel
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] msg_byte_i,
  input  logic       last_byte_i,
  // result channel
  output logic       empty_o,
  input  logic       pop_i,
  output logic [2:0] outcome_o,
  output logic       lun_valid_o,
  output logic [4:0] lun_o,
  output logic [7:0] sync_period_o,
  output logic [7:0] sync_offset_o,
  output logic       reply_valid_o,
  output logic [7:0] reply_byte_o,
  output logic       run_last_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  logic               sync_en_q;
  logic [7:0]         max_per_q, max_off_q;
  logic               byte_accept;
  logic               rec_push, rec_full, rec_pop, rec_empty;
  smop_pkg::run_rec_t rec_in, rec_out;
  logic               res_valid;
  smop_pkg::result_t  res;

  // Configuration registers; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_en_q <= 1'b0;
      max_per_q <= smop_pkg::MAX_PER_RST;
      max_off_q <= smop_pkg::MAX_OFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smop_pkg::CFG_SYNC_EN: sync_en_q <= cfg_data_i[0];
        smop_pkg::CFG_MAX_PER: max_per_q <= cfg_data_i;
        smop_pkg::CFG_MAX_OFF: max_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold off new bytes whenever the run queue cannot take a record
  assign full_o      = rec_full;
  assign byte_accept = push_i && !rec_full;

  smop_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (byte_accept),
    .msg_byte_i    (msg_byte_i),
    .last_byte_i   (last_byte_i),
    .sync_enable_i (sync_en_q),
    .rec_push_o    (rec_push),
    .rec_o         (rec_in)
  );

  smop_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rdata_o (rec_out),
    .empty_o (rec_empty)
  );

  smop_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_empty_i  (rec_empty),
    .rec_i        (rec_out),
    .rec_pop_o    (rec_pop),
    .max_period_i (max_per_q),
    .max_offset_i (max_off_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop_i)
  );

  assign empty_o       = !res_valid;
  assign outcome_o     = res.outcome;
  assign lun_valid_o   = res.lun_valid;
  assign lun_o         = res.lun;
  assign sync_period_o = res.sync_period;
  assign sync_offset_o = res.sync_offset;
  assign reply_valid_o = res.reply_valid;
  assign reply_byte_o  = res.reply_byte;
  assign run_last_o    = res.run_last;

  // The scanner never pushes a record into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !rec_full)
    else $error("run record pushed into a full queue");

  // Only reject and SDTR words carry a reply byte
  a_reply_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (reply_valid_o ==
      (outcome_o == smop_pkg::OUT_REJECT || outcome_o == smop_pkg::OUT_SDTR)))
    else $error("reply flag does not match the outcome");

  // The closing SDTR word repeats the stored offset as its reply byte
  a_sdtr_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && run_last_o && outcome_o == smop_pkg::OUT_SDTR) |->
      (reply_byte_o == sync_offset_o))
    else $error("last SDTR reply byte differs from the stored offset");

  // Single-word outcomes always close their run
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && outcome_o != smop_pkg::OUT_SDTR) |-> run_last_o)
    else $error("single-word outcome without run_last");

endmodule

// File: dv/tb_scsi_message_out_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scsi_message_out_parser: self-checking bench for the message-out parser
// Streams message-out bytes through the byte queue and works out every
// result word in a predictor of its own. Each popped word is compared field
// by field with the oldest prediction. A short scripted opening covers the
// field extremes, every outcome but overlong, and the corner cases. One very
// long run probes the overlong limit. Random runs follow under changing register
// settings, with random gaps on both queues.
// ----------------------------------------------------------------------------
module tb_scsi_message_out_parser;

  localparam int         CLK_PERIOD    = 20;
  localparam int         RANDOM_BYTES  = 120;  // stop the random part here
  localparam int         CALM_BYTES    = 90;   // no gaps on either side past this
  localparam int         SETTLE_CYCLES = 8;    // pause before a register write
  localparam int         STALL_LIMIT   = 2000; // cycles with no word moving
  localparam logic [1:0] CFG_UNUSED    = 2'd3; // index past the register list
  localparam logic [7:0] MSG_IDENTIFY  = 8'h80; // IDENTIFY is 0x80 and above

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_e;
  typedef enum logic [2:0] {RUN_SDTR, RUN_ABORT, RUN_RESET, RUN_PLAIN, RUN_NOISE} run_kind_e;

  // One line of the opening script. For a byte line, typed marks a run whose
  // single result word is written out by hand in word.
  typedef struct {
    row_kind_e          kind;
    logic [1:0]         idx;
    logic [7:0]         data;
    logic               last;
    logic               typed;
    smop_pkg::result_t  word;
  } script_row_t;

  localparam smop_pkg::result_t NO_WORD = '0;

  // Opening script. Register lines wait for the parser to go idle first.
  script_row_t msg_script [33] = '{
    // reset settings: sync off, clamps 50 / 16, stored period and offset 0
    '{ROW_BYTE, 2'd0, 8'h00, 1'b1, 1'b1,
      '{smop_pkg::OUT_GO, 1'b0, 5'd0, 8'd0, 8'd0, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b1, 1'b1,
      '{smop_pkg::OUT_GO, 1'b1, 5'd31, 8'd0, 8'd0, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, 2'd0, 8'h80, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_ABORT, 1'b1, 1'b1,
      '{smop_pkg::OUT_ABORT, 1'b1, 5'd0, 8'd0, 8'd0, 1'b0, 8'h00, 1'b1}},
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_BDR, 1'b1, 1'b1,
      '{smop_pkg::OUT_RESET, 1'b0, 5'd0, 8'd0, 8'd0, 1'b0, 8'h00, 1'b1}},
    // a well-formed SDTR request with sync still off is rejected
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_LEN_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_CODE_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'h64, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b1, 1'b1,
      '{smop_pkg::OUT_REJECT, 1'b0, 5'd0, 8'd0, 8'd0, 1'b1, smop_pkg::MSG_REJECT, 1'b1}},
    '{ROW_REG, smop_pkg::CFG_SYNC_EN, 8'h01, 1'b0, 1'b0, NO_WORD},
    // IDENTIFY then SDTR above both reset clamps
    '{ROW_BYTE, 2'd0, 8'h9F, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_LEN_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_CODE_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'h64, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'h20, 1'b1, 1'b0, NO_WORD},
    // extended with a foreign code, cut short
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_LEN_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'h02, 1'b1, 1'b0, NO_WORD},
    // extended as the last byte: missing bytes read as zero
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b1, 1'b0, NO_WORD},
    '{ROW_REG, smop_pkg::CFG_MAX_PER, 8'h00, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, smop_pkg::CFG_MAX_OFF, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_REG, CFG_UNUSED, 8'hAA, 1'b0, 1'b0, NO_WORD},
    // SDTR at the byte extremes against the clamp extremes
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_LEN_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::EXT_CODE_SDTR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'hFF, 1'b1, 1'b0, NO_WORD},
    // device reset then a late EXTENDED: the tail is ignored, offset cleared
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_BDR, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_EXTENDED, 1'b1, 1'b0, NO_WORD},
    // abort then IDENTIFY: the LUN after the stop is not recorded
    '{ROW_BYTE, 2'd0, smop_pkg::MSG_ABORT, 1'b0, 1'b0, NO_WORD},
    '{ROW_BYTE, 2'd0, 8'h85, 1'b1, 1'b0, NO_WORD}
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push_i      = 1'b0;
  logic [7:0] msg_byte_i  = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       pop_i       = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = 2'd0;
  logic [7:0] cfg_data_i  = 8'h00;

  logic       full_o;
  logic       empty_o;
  logic [2:0] outcome_o;
  logic       lun_valid_o;
  logic [4:0] lun_o;
  logic [7:0] sync_period_o;
  logic [7:0] sync_offset_o;
  logic       reply_valid_o;
  logic [7:0] reply_byte_o;
  logic       run_last_o;

  // Travels with each byte: use the hand-typed word instead of the prediction
  logic              row_typed = 1'b0;
  smop_pkg::result_t row_word  = '0;

  // Predictor state: per-run scan state, stored sync values, registers
  smop_pkg::scan_mode_e scan_state;
  logic [2:0]           cap_pos;
  logic [7:0]           ext_code, ext_period, ext_offset;
  smop_pkg::pend_e      pending;
  logic                 lun_seen;
  logic [4:0]           lun_id;
  logic [7:0]           run_len;
  logic [7:0]           stored_period, stored_offset;
  logic                 sync_on;
  logic [7:0]           period_cap, offset_cap;

  smop_pkg::result_t expected_words [$];  // words still owed by the parser, oldest first
  smop_pkg::result_t run_words [$];       // words caused by the byte just taken

  int         failures     = 0;
  int         random_bytes = 0;
  int         quiet_cycles = 0;
  int         pop_hold     = 0;
  bit         byte_gaps    = 1'b1;
  bit         pop_stalls   = 1'b1;

  scsi_message_out_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .msg_byte_i    (msg_byte_i),
    .last_byte_i   (last_byte_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .outcome_o     (outcome_o),
    .lun_valid_o   (lun_valid_o),
    .lun_o         (lun_o),
    .sync_period_o (sync_period_o),
    .sync_offset_o (sync_offset_o),
    .reply_valid_o (reply_valid_o),
    .reply_byte_o  (reply_byte_o),
    .run_last_o    (run_last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Return every run variable to its idle value; the stored sync values stay
  function automatic void start_run();
    scan_state = smop_pkg::MODE_SCAN;
    cap_pos    = '0;
    ext_code   = '0;
    ext_period = '0;
    ext_offset = '0;
    pending    = smop_pkg::PEND_GO;
    lun_seen   = 1'b0;
    lun_id     = '0;
    run_len    = '0;
  endfunction

  function automatic smop_pkg::result_t reply_word(smop_pkg::outcome_e outc, logic rv,
                                                   logic [7:0] rb, logic rl);
    smop_pkg::result_t w;
    w.outcome     = outc;
    w.lun_valid   = lun_seen;
    w.lun         = lun_id;
    w.sync_period = stored_period;
    w.sync_offset = stored_offset;
    w.reply_valid = rv;
    w.reply_byte  = rv ? rb : 8'h00;
    w.run_last    = rl;
    return w;
  endfunction

  // Take one message-out byte and leave the words it causes in run_words
  function automatic void parse_byte(logic [7:0] b, logic last);
    run_words.delete();

    // The 256th byte of a run trips overlong; nothing after it counts
    if (scan_state != smop_pkg::MODE_OVERLONG) begin
      if (run_len == smop_pkg::RUN_LEN_MAX) begin
        scan_state = smop_pkg::MODE_OVERLONG;
      end else begin
        run_len++;
        if (scan_state == smop_pkg::MODE_CAPTURE) begin
          // position 0 is the length byte and is dropped
          case (cap_pos)
            smop_pkg::CAP_CODE:   ext_code   = b;
            smop_pkg::CAP_PERIOD: ext_period = b;
            smop_pkg::CAP_OFFSET: ext_offset = b;
            default: ;
          endcase
          cap_pos++;
          if (cap_pos >= smop_pkg::CAP_DONE) scan_state = smop_pkg::MODE_STOPPED;
        end else if (scan_state == smop_pkg::MODE_SCAN) begin
          if (b == smop_pkg::MSG_ABORT) begin
            pending    = smop_pkg::PEND_ABORT;
            scan_state = smop_pkg::MODE_STOPPED;
          end else if (b == smop_pkg::MSG_BDR) begin
            pending    = smop_pkg::PEND_RESET;
            scan_state = smop_pkg::MODE_STOPPED;
          end else if (b >= MSG_IDENTIFY) begin
            lun_seen = 1'b1;
            lun_id   = b[4:0];
          end else if (b == smop_pkg::MSG_EXTENDED) begin
            pending    = smop_pkg::PEND_EXT;
            scan_state = smop_pkg::MODE_CAPTURE;
            cap_pos    = '0;
          end
        end
      end
    end

    if (!last) return;

    // Resolve the run; overlong beats anything seen before it
    if (scan_state == smop_pkg::MODE_OVERLONG) begin
      run_words.push_back(reply_word(smop_pkg::OUT_OVERLONG, 1'b0, 8'h00, 1'b1));
    end else begin
      case (pending)
        smop_pkg::PEND_ABORT: begin
          run_words.push_back(reply_word(smop_pkg::OUT_ABORT, 1'b0, 8'h00, 1'b1));
        end
        smop_pkg::PEND_RESET: begin
          stored_offset = '0;
          run_words.push_back(reply_word(smop_pkg::OUT_RESET, 1'b0, 8'h00, 1'b1));
        end
        smop_pkg::PEND_EXT: begin
          if (!sync_on || ext_code != smop_pkg::EXT_CODE_SDTR) begin
            run_words.push_back(reply_word(smop_pkg::OUT_REJECT, 1'b1,
                                           smop_pkg::MSG_REJECT, 1'b1));
          end else begin
            stored_period = (ext_period > period_cap) ? period_cap : ext_period;
            stored_offset = (ext_offset > offset_cap) ? offset_cap : ext_offset;
            run_words.push_back(reply_word(smop_pkg::OUT_SDTR, 1'b1,
                                           smop_pkg::MSG_EXTENDED, 1'b0));
            run_words.push_back(reply_word(smop_pkg::OUT_SDTR, 1'b1,
                                           smop_pkg::EXT_LEN_SDTR, 1'b0));
            run_words.push_back(reply_word(smop_pkg::OUT_SDTR, 1'b1,
                                           smop_pkg::EXT_CODE_SDTR, 1'b0));
            run_words.push_back(reply_word(smop_pkg::OUT_SDTR, 1'b1, stored_period, 1'b0));
            run_words.push_back(reply_word(smop_pkg::OUT_SDTR, 1'b1, stored_offset, 1'b1));
          end
        end
        default: run_words.push_back(reply_word(smop_pkg::OUT_GO, 1'b0, 8'h00, 1'b1));
      endcase
    end
    start_run();
  endfunction

  // Compare the word on the result ports with the oldest prediction
  function automatic void check_word(smop_pkg::result_t want);
    if (outcome_o !== want.outcome) begin
      $error("outcome: expected %0d, got %0d", want.outcome, outcome_o);
      failures++;
    end
    if (lun_valid_o !== want.lun_valid) begin
      $error("lun_valid: expected %0d, got %0d", want.lun_valid, lun_valid_o);
      failures++;
    end
    if (lun_o !== want.lun) begin
      $error("lun: expected %0d, got %0d", want.lun, lun_o);
      failures++;
    end
    if (sync_period_o !== want.sync_period) begin
      $error("sync_period: expected %0d, got %0d", want.sync_period, sync_period_o);
      failures++;
    end
    if (sync_offset_o !== want.sync_offset) begin
      $error("sync_offset: expected %0d, got %0d", want.sync_offset, sync_offset_o);
      failures++;
    end
    if (reply_valid_o !== want.reply_valid) begin
      $error("reply_valid: expected %0d, got %0d", want.reply_valid, reply_valid_o);
      failures++;
    end
    if (reply_byte_o !== want.reply_byte) begin
      $error("reply_byte: expected %0h, got %0h", want.reply_byte, reply_byte_o);
      failures++;
    end
    if (run_last_o !== want.run_last) begin
      $error("run_last: expected %0d, got %0d", want.run_last, run_last_o);
      failures++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor, result sink and watchdog, all on the rising edge. Values read
  // here are the ones from before the edge, so the order against the
  // stimulus process does not matter. Bytes are predicted before words are
  // checked, as a word can never leave in the cycle its byte arrives.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (push_i && !full_o) begin
      parse_byte(msg_byte_i, last_byte_i);
      if (row_typed) begin
        if (run_words.size() != 0) expected_words.push_back(row_word);
      end else begin
        foreach (run_words[k]) expected_words.push_back(run_words[k]);
      end
    end

    if (pop_i && !empty_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: outcome %0d, reply_byte %0h", outcome_o, reply_byte_o);
        failures++;
      end else begin
        check_word(expected_words.pop_front());
      end
    end

    // Now and then hold pop low for a random burst, counted down in pop_hold
    if (pop_hold != 0) begin
      pop_hold--;
      pop_i <= 1'b0;
    end else if (pop_stalls && $urandom_range(0, 7) == 0) begin
      pop_hold = $urandom_range(0, 9);
      pop_i    <= 1'b0;
    end else begin
      pop_i <= 1'b1;
    end

    if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Mostly random, with the byte extremes one time in three
  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // A byte that neither stops the scan nor opens an extended message
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == smop_pkg::MSG_EXTENDED || b == smop_pkg::MSG_ABORT || b == smop_pkg::MSG_BDR);
    return b;
  endfunction

  // Offer one byte, perhaps after a gap, and hold it until it is taken
  task automatic send_byte(logic [7:0] b, logic last, logic typed, smop_pkg::result_t w);
    if (byte_gaps && $urandom_range(0, 5) == 0) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    msg_byte_i  <= b;
    last_byte_i <= last;
    row_typed   <= typed;
    row_word    <= w;
    do @(posedge clk_i); while (full_o);
  endtask

  // Drop push, wait for every owed word, then let the pipeline drain
  task automatic settle(int tail);
    push_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // Write one register; the predictor follows at the same edge
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      smop_pkg::CFG_SYNC_EN: sync_on    = data[0];
      smop_pkg::CFG_MAX_PER: period_cap = data;
      smop_pkg::CFG_MAX_OFF: offset_cap = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register settings per phase: the extremes first, then random ones
  task automatic load_settings(int phase);
    logic       sync_bit;
    logic [7:0] per, off;
    case (phase)
      0: begin sync_bit = 1'b1; per = 8'hFF; off = 8'hFF; end
      1: begin sync_bit = 1'b1; per = 8'h00; off = 8'h00; end
      2: begin sync_bit = 1'b0; per = corner_byte(); off = corner_byte(); end
      default: begin
        sync_bit = ($urandom_range(0, 4) != 0);
        per      = corner_byte();
        off      = corner_byte();
      end
    endcase
    write_reg(smop_pkg::CFG_SYNC_EN, {7'($urandom), sync_bit});
    write_reg(smop_pkg::CFG_MAX_PER, per);
    write_reg(smop_pkg::CFG_MAX_OFF, off);
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, 8'($urandom));
  endtask

  // Build one run of the given kind, pad it to min_len, and send it
  task automatic send_run(run_kind_e kind, int min_len);
    logic [7:0] run_bytes [$];
    int         cut;
    case (kind)
      RUN_SDTR: begin
        if ($urandom_range(0, 1)) run_bytes.push_back(MSG_IDENTIFY | 8'($urandom_range(0, 127)));
        run_bytes.push_back(smop_pkg::MSG_EXTENDED);
        run_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : smop_pkg::EXT_LEN_SDTR);
        run_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : smop_pkg::EXT_CODE_SDTR);
        run_bytes.push_back(corner_byte());
        run_bytes.push_back(corner_byte());
        // now and then cut the request short
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, run_bytes.size() - 1);
          while (run_bytes.size() > cut) void'(run_bytes.pop_back());
        end
        repeat ($urandom_range(0, 2)) run_bytes.push_back(8'($urandom));
      end
      RUN_ABORT, RUN_RESET: begin
        repeat ($urandom_range(0, 3)) run_bytes.push_back(plain_byte());
        run_bytes.push_back((kind == RUN_ABORT) ? smop_pkg::MSG_ABORT : smop_pkg::MSG_BDR);
        repeat ($urandom_range(0, 3)) run_bytes.push_back(8'($urandom));
      end
      RUN_PLAIN: repeat ($urandom_range(1, 6)) run_bytes.push_back(plain_byte());
      default:   repeat ($urandom_range(1, 8)) run_bytes.push_back(8'($urandom));
    endcase
    while (run_bytes.size() < min_len) run_bytes.push_back(8'($urandom));
    foreach (run_bytes[k]) send_byte(run_bytes[k], k == run_bytes.size() - 1, 1'b0, NO_WORD);
    if (min_len == 0) random_bytes += run_bytes.size();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int        phase;
    int        phase_end;
    int        pick;
    run_kind_e kind;

    // Predictor comes up in the reset state of the parser
    start_run();
    stored_period = '0;
    stored_offset = '0;
    sync_on       = 1'b0;
    period_cap    = smop_pkg::MAX_PER_RST;
    offset_cap    = smop_pkg::MAX_OFF_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Scripted opening; register lines only once the parser is idle
    foreach (msg_script[i]) begin
      if (msg_script[i].kind == ROW_REG) begin
        settle(SETTLE_CYCLES);
        write_reg(msg_script[i].idx, msg_script[i].data);
      end else begin
        send_byte(msg_script[i].data, msg_script[i].last, msg_script[i].typed,
                  msg_script[i].word);
      end
    end

    // Overlong limit: a 256-byte run does not resolve normally, even with
    // an SDTR request at the front and sync enabled
    settle(SETTLE_CYCLES);
    load_settings(0);
    send_run(RUN_SDTR, 256);

    // Random phases: fresh settings, then a batch of runs, mostly well formed
    phase = 1;
    while (random_bytes < RANDOM_BYTES) begin
      settle(SETTLE_CYCLES);
      load_settings(phase);
      phase++;
      // some phases run without gaps; none at all near the end
      byte_gaps  = (random_bytes < CALM_BYTES) && ($urandom_range(0, 3) != 0);
      pop_stalls = (random_bytes < CALM_BYTES) && ($urandom_range(0, 3) != 0);
      phase_end  = random_bytes + $urandom_range(30, 60);
      while (random_bytes < phase_end && random_bytes < RANDOM_BYTES) begin
        if (random_bytes >= CALM_BYTES) begin
          byte_gaps  = 1'b0;
          pop_stalls = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = RUN_SDTR;
        else if (pick < 52) kind = RUN_ABORT;
        else if (pick < 64) kind = RUN_RESET;
        else if (pick < 82) kind = RUN_PLAIN;
        else                kind = RUN_NOISE;
        send_run(kind, 0);
      end
    end

    // Drain and watch a little longer for stray words
    settle(4 * SETTLE_CYCLES);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: scsi_message_out_parser.f
rtl/smop_pkg.sv
rtl/smop_front.sv
rtl/smop_fifo.sv
rtl/smop_back.sv
rtl/scsi_message_out_parser.sv
dv/tb_scsi_message_out_parser.sv
